[sv/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge, skipped while reset is high.
`define NVQE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property on every rising edge, reset included.
`define NVQE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define NVQE_ASSERT(label, clk, rst, prop, msg)
`define NVQE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[sv/nvqe_pkg.sv]
package nvqe_pkg;

  // Default largest queue depth the pointers are sized for.
  localparam int DEF_MAX_QUEUE_DEPTH = 64;

  // Doorbell register block base offset.
  localparam logic [18:0] DB_BASE = 19'h01000;

  // Configuration register indexes.
  localparam logic [1:0] REG_QUEUE_DEPTH = 2'd0;
  localparam logic [1:0] REG_DB_STRIDE   = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [6:0] RST_QUEUE_DEPTH = 7'd64;
  localparam logic [3:0] RST_DB_STRIDE   = 4'd0;

  typedef enum logic [1:0] {
    KIND_SLOT     = 2'd0,
    KIND_DOORBELL = 2'd1,
    KIND_ACCEPT   = 2'd2,
    KIND_NOTREADY = 2'd3
  } kind_t;

  typedef enum logic {
    ACT_SUBMIT     = 1'b0,
    ACT_COMPLETION = 1'b1
  } action_t;

  typedef struct packed {
    logic        action;
    logic        queue_id;
    logic [15:0] command_word0;
    logic [15:0] cqe_status;
    logic [15:0] cqe_cid;
    logic [31:0] cqe_result;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic        out_queue;
    logic [5:0]  slot_index;
    logic [31:0] dword0;
    logic [18:0] doorbell_offset;
    logic [5:0]  doorbell_value;
    logic        status_error;
    logic [14:0] status_code;
    logic [31:0] result_dword;
    logic        last;
  } rsp_t;

  // Load request into the result buffer.
  typedef struct packed {
    logic valid;
    logic pair;
  } push_t;

  // Byte offset of doorbell c (0 tail, 1 head) of queue pair q.
  function automatic logic [18:0] db_offset(input logic q, input logic c,
                                            input logic [3:0] stride_exp);
    logic [18:0] slot;
    slot = {17'd0, q, c};
    return DB_BASE + ((slot << 2) << stride_exp);
  endfunction

endpackage

[sv/nvqe_rbuf.sv]
module nvqe_rbuf (
  input  logic          clk,
  input  logic          rst,
  input  nvqe_pkg::push_t push,
  input  nvqe_pkg::rsp_t  word0,
  input  nvqe_pkg::rsp_t  word1,
  output logic          ready,
  output logic          res_valid,
  input  logic          res_ready,
  output nvqe_pkg::rsp_t  res_word
);
  import nvqe_pkg::*;

  logic [1:0] cnt;
  logic [1:0] cnt_next;
  rsp_t       first;
  rsp_t       second;
  logic       pop;

  assign res_valid = (cnt != 2'd0);
  assign res_word  = first;
  assign pop       = res_valid && res_ready;

  // Take a new pair once the buffer is empty or its last word leaves now.
  assign ready = (cnt == 2'd0) || ((cnt == 2'd1) && res_ready);

  always_comb begin
    cnt_next = cnt;
    if (push.valid) begin
      cnt_next = push.pair ? 2'd2 : 2'd1;
    end else if (pop) begin
      cnt_next = cnt - 2'd1;
    end
  end

  // Load a fresh pair, or advance the second word to the front.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
    if (push.valid) begin
      first  <= word0;
      second <= word1;
    end else if (pop) begin
      first <= second;
    end
  end

`include "assert_macros.svh"
  `NVQE_ASSERT(a_cnt_range, clk, rst, cnt != 2'd3, "result buffer count out of range")
  `NVQE_ASSERT(a_push_room, clk, rst, push.valid |-> ready, "pair loaded over a waiting word")
  `NVQE_ASSERT(a_shift, clk, rst, (pop && !push.valid && cnt == 2'd2) |=> (res_valid && res_word == $past(second)), "second word lost on advance")
  `NVQE_ASSERT(a_last_end, clk, rst, (res_valid && cnt == 2'd1) |-> res_word.last, "final word of an item without last")

endmodule

[sv/nvme_queue_pair_engine.sv]
// The first result word is offered in the cycle after its item is accepted.
// One result word per cycle while res_ready is high; a submit or accepted completion
// gives two result words, a not-ready one gives one, and the next item is taken in the
// cycle the previous item's last word leaves. A stalled result port stalls the input.
// Reset (synchronous, rst high): command id 1, no pending ids, tails and heads 0,
// phase tags 1, queue depth 64, doorbell stride exponent 0, result buffer empty.
module nvme_queue_pair_engine #(
  parameter int MAX_QUEUE_DEPTH = nvqe_pkg::DEF_MAX_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  nvqe_pkg::cmd_t cmd_word,
  output logic           res_valid,
  input  logic           res_ready,
  output nvqe_pkg::rsp_t res_word,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [6:0]     cfg_data
);
  import nvqe_pkg::*;

  localparam int IDX_W = $clog2(MAX_QUEUE_DEPTH);
  localparam int CMP_W = (IDX_W + 1 > 7) ? IDX_W + 1 : 7;
  localparam logic [CMP_W-1:0] DEPTH_MIN = CMP_W'(2);
  localparam logic [CMP_W-1:0] DEPTH_MAX = CMP_W'(MAX_QUEUE_DEPTH);

  logic [6:0]       qdepth;
  logic [3:0]       doorbell_stride_exp;
  logic [15:0]      next_command_id;
  logic [15:0]      pending_command_id [2];
  logic [IDX_W-1:0] sq_tail [2];
  logic [IDX_W-1:0] cq_head [2];
  logic             cq_phase [2];

  logic [CMP_W-1:0] eff_depth;
  logic             accept;
  logic             q;
  logic             is_submit;
  logic             matched;
  logic [15:0]      id_inc;
  logic [15:0]      command_id_next;
  logic [IDX_W-1:0] sq_tail_next;
  logic [IDX_W-1:0] cq_head_next;
  logic [14:0]      code;
  rsp_t             word0;
  rsp_t             word1;
  push_t            push;

  // Step an index, wrapping once it reaches the effective depth.
  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [CMP_W-1:0] depth);
    logic [CMP_W-1:0] n;
    n = CMP_W'(idx) + CMP_W'(1);
    return (n >= depth) ? '0 : IDX_W'(n);
  endfunction

  // Clamp the programmed depth into the supported range.
  always_comb begin
    eff_depth = CMP_W'(qdepth);
    if (eff_depth < DEPTH_MIN) begin
      eff_depth = DEPTH_MIN;
    end else if (eff_depth > DEPTH_MAX) begin
      eff_depth = DEPTH_MAX;
    end
  end

  assign q         = cmd_word.queue_id;
  assign is_submit = (cmd_word.action == ACT_SUBMIT);
  assign accept    = cmd_valid && cmd_ready;
  assign code      = cmd_word.cqe_status[15:1];

  assign id_inc          = next_command_id + 16'd1;
  assign command_id_next = (id_inc == 16'd0) ? 16'd1 : id_inc;
  assign sq_tail_next    = advance(sq_tail[q], eff_depth);
  assign cq_head_next    = advance(cq_head[q], eff_depth);

  assign matched = (pending_command_id[q] != 16'd0) &&
                   (cmd_word.cqe_status[0] == cq_phase[q]) &&
                   (cmd_word.cqe_cid == pending_command_id[q]);

  // Build the result words for the item on the input.
  always_comb begin
    word0 = '0;
    word1 = '0;
    word0.out_queue = q;
    word1.out_queue = q;
    word1.kind      = KIND_DOORBELL;
    word1.last      = 1'b1;
    if (is_submit) begin
      word0.kind            = KIND_SLOT;
      word0.slot_index      = 6'(sq_tail[q]);
      word0.dword0          = {next_command_id, cmd_word.command_word0};
      word1.doorbell_offset = db_offset(q, 1'b0, doorbell_stride_exp);
      word1.doorbell_value  = 6'(sq_tail_next);
    end else if (matched) begin
      word0.kind            = KIND_ACCEPT;
      word0.status_error    = (code != 15'd0);
      word0.status_code     = code;
      word0.result_dword    = cmd_word.cqe_result;
      word1.doorbell_offset = db_offset(q, 1'b1, doorbell_stride_exp);
      word1.doorbell_value  = 6'(cq_head_next);
    end else begin
      word0.kind = KIND_NOTREADY;
      word0.last = 1'b1;
    end
  end

  assign push.valid = accept;
  assign push.pair  = is_submit || matched;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      qdepth              <= RST_QUEUE_DEPTH;
      doorbell_stride_exp <= RST_DB_STRIDE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_QUEUE_DEPTH: qdepth              <= cfg_data;
        REG_DB_STRIDE:   doorbell_stride_exp <= cfg_data[3:0];
        default:         ;
      endcase
    end
  end

  // Advance queue state on each accepted submit or matched completion.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_command_id <= 16'd1;
      for (int i = 0; i < 2; i++) begin
        pending_command_id[i] <= 16'd0;
        sq_tail[i]            <= '0;
        cq_head[i]            <= '0;
        cq_phase[i]           <= 1'b1;
      end
    end else if (accept) begin
      if (is_submit) begin
        next_command_id       <= command_id_next;
        pending_command_id[q] <= next_command_id;
        sq_tail[q]            <= sq_tail_next;
      end else if (matched) begin
        pending_command_id[q] <= 16'd0;
        cq_head[q]            <= cq_head_next;
        if (cq_head_next == '0) begin
          cq_phase[q] <= ~cq_phase[q];
        end
      end
    end
  end

  nvqe_rbuf u_rbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .word0     (word0),
    .word1     (word1),
    .ready     (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
  );

`include "assert_macros.svh"
  `NVQE_ASSERT_ALWAYS(a_id_nonzero, clk, !rst |-> next_command_id != 16'd0, "command id counter reached zero")
  `NVQE_ASSERT(a_submit_pending, clk, rst, (accept && is_submit) |=> pending_command_id[$past(q)] == $past(next_command_id), "submitted id not recorded as pending")
  `NVQE_ASSERT(a_match_clears, clk, rst, (accept && !is_submit && matched) |=> pending_command_id[$past(q)] == 16'd0, "accepted completion left its id pending")

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import nvqe_pkg::*;

  localparam int MAX_DEPTH    = DEF_MAX_QUEUE_DEPTH;
  localparam int LIMIT_CYCLES = 1000000;

  // Bookkeeping of both queue pairs plus the two registers
  typedef struct packed {
    logic [6:0]       depth;
    logic [3:0]       stride_exp;
    logic [15:0]      next_id;
    logic [1:0][15:0] pending_cid;
    logic [1:0][5:0]  sq_tail;
    logic [1:0][5:0]  cq_head;
    logic [1:0]       cq_phase;
  } pair_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd_word = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  rsp_t res_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_QUEUE_DEPTH;
  logic [6:0] cfg_data = '0;

  cmd_t cmd_backlog[$];
  rsp_t owed_responses[$];
  pair_state_t live_state;
  pair_state_t plan_state;
  logic cmd_fired = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;

  nvme_queue_pair_engine DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_word(cmd_word),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_word(res_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic pair_state_t fresh_state();
    pair_state_t st;
    st = '0;
    st.depth = RST_QUEUE_DEPTH;
    st.stride_exp = RST_DB_STRIDE;
    st.next_id = 16'd1;
    st.cq_phase = 2'b11;
    return st;
  endfunction

  // Step an index; clamp the depth to 2..MAX_DEPTH, wrap on reaching it
  function automatic logic [5:0] wrap_index(input pair_state_t st, input logic [5:0] idx);
    int unsigned lim;
    int unsigned n;
    lim = st.depth;
    if (lim < 2) lim = 2;
    if (lim > MAX_DEPTH) lim = MAX_DEPTH;
    n = idx + 1;
    return (n >= lim) ? 6'd0 : n[5:0];
  endfunction

  // Tail doorbell (head = 0) or head doorbell (head = 1) of pair q
  function automatic logic [18:0] bell_offset(input pair_state_t st, input logic q,
                                              input logic head);
    int unsigned off;
    off = DB_BASE + (2 * q + head) * (4 << st.stride_exp);
    return off[18:0];
  endfunction

  // Apply one command to the bookkeeping and return the words it produces
  function automatic int step_queue_pairs(inout pair_state_t st, input cmd_t c,
                                          output rsp_t r0, output rsp_t r1);
    logic        q;
    logic [15:0] cid;
    logic [15:0] nxt;
    r0 = '0;
    r1 = '0;
    q = c.queue_id;
    r0.out_queue = q;
    r1.out_queue = q;
    r1.kind = KIND_DOORBELL;
    r1.last = 1'b1;
    if (c.action == ACT_SUBMIT) begin
      cid = st.next_id;
      nxt = cid + 16'd1;
      st.next_id = (nxt == 16'd0) ? 16'd1 : nxt;
      st.pending_cid[q] = cid;
      r0.kind = KIND_SLOT;
      r0.slot_index = st.sq_tail[q];
      r0.dword0 = {cid, c.command_word0};
      st.sq_tail[q] = wrap_index(st, st.sq_tail[q]);
      r1.doorbell_offset = bell_offset(st, q, 1'b0);
      r1.doorbell_value = st.sq_tail[q];
      return 2;
    end
    if (st.pending_cid[q] != 16'd0 && c.cqe_status[0] == st.cq_phase[q] &&
        c.cqe_cid == st.pending_cid[q]) begin
      st.pending_cid[q] = 16'd0;
      st.cq_head[q] = wrap_index(st, st.cq_head[q]);
      if (st.cq_head[q] == 6'd0) st.cq_phase[q] = ~st.cq_phase[q];
      r0.kind = KIND_ACCEPT;
      r0.status_code = c.cqe_status[15:1];
      r0.status_error = |c.cqe_status[15:1];
      r0.result_dword = c.cqe_result;
      r1.doorbell_offset = bell_offset(st, q, 1'b1);
      r1.doorbell_value = st.cq_head[q];
      return 2;
    end
    r0.kind = KIND_NOTREADY;
    r0.last = 1'b1;
    return 1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  task automatic compare_response(input rsp_t want, input rsp_t got);
    check_field("kind", want.kind, got.kind);
    check_field("out_queue", want.out_queue, got.out_queue);
    check_field("slot_index", want.slot_index, got.slot_index);
    check_field("dword0", want.dword0, got.dword0);
    check_field("doorbell_offset", want.doorbell_offset, got.doorbell_offset);
    check_field("doorbell_value", want.doorbell_value, got.doorbell_value);
    check_field("status_error", want.status_error, got.status_error);
    check_field("status_code", want.status_code, got.status_code);
    check_field("result_dword", want.result_dword, got.result_dword);
    check_field("last", want.last, got.last);
  endtask

  // Monitor: track config writes, predict on each command word, check result words
  always @(posedge clk) begin : monitor
    rsp_t r0;
    rsp_t r1;
    rsp_t want;
    int n;
    cmd_fired = cmd_valid && cmd_ready && !rst;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_QUEUE_DEPTH) live_state.depth = cfg_data;
        else if (cfg_index == REG_DB_STRIDE) live_state.stride_exp = cfg_data[3:0];
      end
      if (cmd_fired) begin
        n = step_queue_pairs(live_state, cmd_word, r0, r1);
        owed_responses.push_back(r0);
        if (n == 2) owed_responses.push_back(r1);
      end
      if (res_valid && res_ready) begin
        if (owed_responses.size() == 0) begin
          fail_count++;
          $display("%0t: result expected none, got %h", $time, res_word);
        end else begin
          want = owed_responses.pop_front();
          compare_response(want, res_word);
        end
      end
    end
  end

  // Driver: present the next command word once the last one is taken; stall results
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_fired) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd_word <= cmd_backlog.pop_front();
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
    res_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic add_item(input cmd_t c);
    rsp_t r0;
    rsp_t r1;
    void'(step_queue_pairs(plan_state, c, r0, r1));
    cmd_backlog.push_back(c);
  endtask

  task automatic add_fields(input action_t act, input logic q, input logic [15:0] cw0,
                            input logic [15:0] status, input logic [15:0] cid,
                            input logic [31:0] result);
    cmd_t c;
    c.action = act;
    c.queue_id = q;
    c.command_word0 = cw0;
    c.cqe_status = status;
    c.cqe_cid = cid;
    c.cqe_result = result;
    add_item(c);
  endtask

  // Mostly submits and matching completions, some broken completions; only submits if submits_only
  task automatic add_random_item(input bit submits_only);
    cmd_t c;
    logic q;
    int roll;
    c.command_word0 = 16'($urandom);
    c.cqe_status = 16'($urandom);
    c.cqe_cid = 16'($urandom);
    c.cqe_result = $urandom;
    q = 1'($urandom_range(1));
    c.queue_id = q;
    c.action = ACT_COMPLETION;
    roll = $urandom_range(99);
    if (submits_only || roll < 45) begin
      c.action = ACT_SUBMIT;
    end else if (roll < 85) begin
      if (plan_state.pending_cid[q] == 16'd0) begin
        c.action = ACT_SUBMIT;
      end else begin
        c.cqe_cid = plan_state.pending_cid[q];
        c.cqe_status[0] = plan_state.cq_phase[q];
        if ($urandom_range(1)) c.cqe_status[15:1] = '0;
      end
    end else begin
      case ($urandom_range(2))
        0: begin
          c.cqe_cid = plan_state.pending_cid[q];
          c.cqe_status[0] = ~plan_state.cq_phase[q];
        end
        1: begin
          c.cqe_cid = plan_state.pending_cid[q] ^ (16'd1 << $urandom_range(15));
          c.cqe_status[0] = plan_state.cq_phase[q];
        end
        default: ;
      endcase
    end
    add_item(c);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every command is taken and every result word has come back
  task automatic wait_drained();
    do @(posedge clk);
    while (cmd_backlog.size() != 0 || cmd_valid || owed_responses.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [6:0] depth, input logic [3:0] stride,
                           input int idle, input int stall, input int count,
                           input bit submits_only);
    wait_drained();
    send_idle_pct = idle;
    recv_stall_pct = stall;
    write_reg(REG_QUEUE_DEPTH, depth);
    write_reg(REG_DB_STRIDE, {3'd0, stride});
    plan_state.depth = depth;
    plan_state.stride_exp = stride;
    repeat (count) add_random_item(submits_only);
  endtask

  initial begin
    live_state = fresh_state();
    plan_state = fresh_state();
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed: nothing pending, wrong phase, wrong id, replaced id, status extremes
    add_fields(ACT_COMPLETION, 1'b0, 16'h0000, 16'h0001, 16'h0000, 32'h0000_0000);
    add_fields(ACT_SUBMIT, 1'b0, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
    add_fields(ACT_COMPLETION, 1'b0, 16'h0000, 16'h0000, 16'd1, 32'h0000_0000);
    add_fields(ACT_COMPLETION, 1'b0, 16'h0000, 16'h0001, 16'd2, 32'h0000_0000);
    add_fields(ACT_COMPLETION, 1'b0, 16'h0000, 16'h0001, 16'd1, 32'hFFFF_FFFF);
    add_fields(ACT_COMPLETION, 1'b0, 16'h0000, 16'h0001, 16'd1, 32'h0000_0000);
    add_fields(ACT_SUBMIT, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    add_fields(ACT_COMPLETION, 1'b1, 16'hFFFF, 16'hFFFF, 16'd2, 32'h0000_0000);
    add_fields(ACT_SUBMIT, 1'b0, 16'h1234, 16'h0000, 16'h0000, 32'h0000_0000);
    add_fields(ACT_SUBMIT, 1'b0, 16'hA5C3, 16'h0000, 16'h0000, 32'h0000_0000);
    add_fields(ACT_COMPLETION, 1'b0, 16'h0000, 16'h0001, 16'd3, 32'h1234_5678);
    add_fields(ACT_COMPLETION, 1'b0, 16'h0000, 16'h0003, 16'd4, 32'h8765_4321);
    add_fields(ACT_SUBMIT, 1'b1, 16'h00FF, 16'h0000, 16'h0000, 32'h0000_0000);
    add_fields(ACT_COMPLETION, 1'b1, 16'h0000, 16'h8001, 16'd5, 32'h8000_0001);
    add_fields(ACT_COMPLETION, 1'b1, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);

    // Random phases over depth and stride extremes and the idling mixes
    run_phase(7'd64, 4'd0, 0, 0, 300, 1'b0);
    run_phase(7'd2, 4'd15, 56, 0, 300, 1'b0);
    run_phase(7'd127, 4'd9, 0, 56, 300, 1'b0);
    run_phase(7'd1, 4'($urandom_range(15)), 15, 15, 250, 1'b0);
    run_phase(7'($urandom_range(63, 3)), 4'($urandom_range(15)), 0, 0, 100, 1'b0);
    // Run submits only with a zero depth so the tails wrap at the clamped minimum
    run_phase(7'd0, 4'd4, 0, 0, 60, 1'b1);
    run_phase(7'($urandom_range(64, 2)), 4'($urandom_range(15)), 15, 15, 150, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/nvqe_pkg.sv
sv/nvqe_rbuf.sv
sv/nvme_queue_pair_engine.sv
sim/testbench.sv
